// ===== src/tdss_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tdss_pkg
// Shared constants and segment tables for the three-digit display shifter.
// ----------------------------------------------------------------------------
package tdss_pkg;

  localparam int NUM_W      = 16;
  localparam int WORD_W     = 32;
  localparam int SEG_W      = 16;
  localparam int DIGIT_W    = 4;
  localparam int Q1_W       = 13;  // number / 10 fits in 13 bits
  localparam int Q2_W       = 10;  // number / 100 fits in 10 bits
  localparam int Q3_W       = 7;   // number / 1000 fits in 7 bits

  // divide by 10 through reciprocal multiply
  localparam logic [15:0] DIV10_MUL_WIDE  = 16'hCCCD;
  localparam int          DIV10_SHR_WIDE  = 19;
  localparam logic [7:0]  DIV10_MUL_NARROW = 8'd205;
  localparam int          DIV10_SHR_NARROW = 11;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [SEG_W-1:0]   seg_t;
  typedef logic [WORD_W-1:0]  word_t;

  // hundreds and ones positions: PCDE--------GFAB
  function automatic seg_t seg_outer(input digit_t d);
    seg_t p;
    case (d)
      4'd0:    p = 16'h7007;
      4'd1:    p = 16'h4001;
      4'd2:    p = 16'h300B;
      4'd3:    p = 16'h600B;
      4'd4:    p = 16'h400D;
      4'd5:    p = 16'h600E;
      4'd6:    p = 16'h700E;
      4'd7:    p = 16'h4003;
      4'd8:    p = 16'h700F;
      4'd9:    p = 16'h600F;
      default: p = '0;
    endcase
    return p;
  endfunction

  // tens position: ----PCDEGFAB----
  function automatic seg_t seg_middle(input digit_t d);
    seg_t p;
    case (d)
      4'd0:    p = 16'h0770;
      4'd1:    p = 16'h0410;
      4'd2:    p = 16'h03B0;
      4'd3:    p = 16'h06B0;
      4'd4:    p = 16'h04D0;
      4'd5:    p = 16'h06E0;
      4'd6:    p = 16'h07E0;
      4'd7:    p = 16'h0430;
      4'd8:    p = 16'h07F0;
      4'd9:    p = 16'h06F0;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== src/three_digit_seven_segment_shifter_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// three_digit_seven_segment_shifter_core
// Splits a 16-bit number into three decimal digits and streams the segment
// word out serially for an external shift register.
//
// Input channel in_*: one 16-bit number per beat; only the low three decimal
// digits are shown. Output channel out_*: SHIFT_LENGTH beats per number,
// word bit 0 first; out_latch is high on the last beat of each word.
// Path from input beat to the first output beat: three digit-split stages,
// the queue head, the output register. The one-bit-per-beat serializer sets
// the rate of one number per SHIFT_LENGTH beats; the digit pipe and a
// two-word queue let new numbers be taken while a word is sent.
// Reset (rst_n low, synchronous) empties all stages; no beats are pending.
// A stalled receiver holds the current beat; the serializer and then the
// queue and digit pipe fill up, and in_ready drops once all are full.
// ----------------------------------------------------------------------------
module three_digit_seven_segment_shifter_core
  import tdss_pkg::*;
#(
  parameter int SHIFT_LENGTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [NUM_W-1:0]  in_number,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_serial_bit,
  output logic                   out_latch
);

  logic  f_valid, f_ready;
  word_t f_word;
  logic  q_valid, q_ready;
  word_t q_word;

  tdss_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_number  (in_number),
    .word_valid (f_valid),
    .word_ready (f_ready),
    .word       (f_word)
  );

  tdss_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_word  (f_word),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_word   (q_word)
  );

  tdss_back #(
    .SHIFT_LENGTH (SHIFT_LENGTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .word_valid     (q_valid),
    .word_ready     (q_ready),
    .word           (q_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_serial_bit (out_serial_bit),
    .out_latch      (out_latch)
  );

endmodule
`default_nettype wire

// ===== src/tdss_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tdss_front
// Three-stage elastic pipe: splits the number into decimal digits and
// builds the 32-bit segment word.
// ----------------------------------------------------------------------------
module tdss_front
  import tdss_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [NUM_W-1:0]  in_number,
  output logic                   word_valid,
  input  wire logic              word_ready,
  output word_t                  word
);

  logic             v1_r, v2_r, v3_r;
  logic             v1_nxt, v2_nxt, v3_nxt;
  logic             rdy1, rdy2, rdy3;
  logic [Q1_W-1:0]  q1_r;
  digit_t           o1_r, o2_r, t2_r;
  logic [Q2_W-1:0]  q2_r;
  word_t            word_r;

  logic [31:0]      prod1;
  logic [Q1_W-1:0]  q1_c;
  logic [NUM_W-1:0] ten_q1;
  logic [NUM_W-1:0] o1_full;
  logic [28:0]      prod2;
  logic [Q2_W-1:0]  q2_c;
  logic [Q1_W-1:0]  ten_q2;
  logic [Q1_W-1:0]  t_full;
  logic [17:0]      prod3;
  logic [Q3_W-1:0]  q3_c;
  logic [Q2_W-1:0]  ten_q3;
  logic [Q2_W-1:0]  h_full;
  word_t            word_c;

  assign rdy3     = !v3_r || word_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // stage 1: ones digit
  always_comb begin
    prod1   = in_number * DIV10_MUL_WIDE;
    q1_c    = prod1[DIV10_SHR_WIDE +: Q1_W];
    ten_q1  = {q1_c, 3'b000} + {2'b00, q1_c, 1'b0};
    o1_full = in_number - ten_q1;
  end

  // stage 2: tens digit
  always_comb begin
    prod2  = q1_r * DIV10_MUL_WIDE;
    q2_c   = prod2[DIV10_SHR_WIDE +: Q2_W];
    ten_q2 = {q2_c, 3'b000} + {2'b00, q2_c, 1'b0};
    t_full = q1_r - ten_q2;
  end

  // stage 3: hundreds digit modulo 10, table lookup
  always_comb begin
    prod3  = q2_r * DIV10_MUL_NARROW;
    q3_c   = prod3[DIV10_SHR_NARROW +: Q3_W];
    ten_q3 = {q3_c, 3'b000} + {2'b00, q3_c, 1'b0};
    h_full = q2_r - ten_q3;
    word_c = {seg_outer(h_full[DIGIT_W-1:0]), {SEG_W{1'b0}}}
           | {{SEG_W{1'b0}}, seg_middle(t2_r)}
           | {{SEG_W{1'b0}}, seg_outer(o2_r)};
  end

  always_comb begin
    v1_nxt = rdy1 ? in_valid : v1_r;
    v2_nxt = rdy2 ? v1_r : v2_r;
    v3_nxt = rdy3 ? v2_r : v3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      q1_r <= q1_c;
      o1_r <= o1_full[DIGIT_W-1:0];
    end
    if (rdy2) begin
      q2_r <= q2_c;
      t2_r <= t_full[DIGIT_W-1:0];
      o2_r <= o1_r;
    end
    if (rdy3) begin
      word_r <= word_c;
    end
  end

  assign word_valid = v3_r;
  assign word       = word_r;

endmodule
`default_nettype wire

// ===== src/tdss_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tdss_queue
// Two-entry word queue between the digit pipe and the serializer.
// ----------------------------------------------------------------------------
module tdss_queue
  import tdss_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push_valid,
  output logic       push_ready,
  input  wire word_t push_word,
  output logic       pop_valid,
  input  wire logic  pop_ready,
  output word_t      pop_word
);

  logic  head_v_r, tail_v_r;
  logic  head_v_nxt, tail_v_nxt;
  word_t head_r, tail_r;
  logic  push, pop;

  assign push_ready = !tail_v_r;
  assign pop_valid  = head_v_r;
  assign pop_word   = head_r;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    head_v_nxt = head_v_r;
    tail_v_nxt = tail_v_r;
    if (pop) begin
      head_v_nxt = tail_v_r || push;
      tail_v_nxt = tail_v_r && push;
    end else if (push) begin
      head_v_nxt = 1'b1;
      tail_v_nxt = head_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      tail_v_r <= 1'b0;
    end else begin
      head_v_r <= head_v_nxt;
      tail_v_r <= tail_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      head_r <= tail_v_r ? tail_r : push_word;
    end else if (push && !head_v_r) begin
      head_r <= push_word;
    end
    if (push && ((head_v_r && !pop) || (tail_v_r && pop))) begin
      tail_r <= push_word;
    end
  end

endmodule
`default_nettype wire

// ===== src/tdss_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tdss_back
// Serializer: sends each word LSB first, one bit per beat, latch mark on
// the last bit.
// ----------------------------------------------------------------------------
module tdss_back
  import tdss_pkg::*;
#(
  parameter int SHIFT_LENGTH = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  word_valid,
  output logic       word_ready,
  input  wire word_t word,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic       out_serial_bit,
  output logic       out_latch
);

  localparam int IDX_W = $clog2(SHIFT_LENGTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SHIFT_LENGTH - 1);

  logic                    busy_r, busy_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_bit_r, out_bit_nxt;
  logic                    out_latch_r, out_latch_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [SHIFT_LENGTH-1:0] shreg_r, shreg_nxt;
  logic [SHIFT_LENGTH+WORD_W-1:0] word_ext;
  logic [SHIFT_LENGTH-1:0] word_fit;
  logic                    advance;

  // zero-extend or truncate the word to the shift length
  assign word_ext   = {{SHIFT_LENGTH{1'b0}}, word};
  assign word_fit   = word_ext[SHIFT_LENGTH-1:0];
  assign advance    = !out_valid_r || out_ready;
  assign word_ready = advance && !busy_r;

  always_comb begin
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    out_bit_nxt   = out_bit_r;
    out_latch_nxt = out_latch_r;
    idx_nxt       = idx_r;
    shreg_nxt     = shreg_r;
    if (advance) begin
      if (busy_r) begin
        out_valid_nxt = 1'b1;
        out_bit_nxt   = shreg_r[0];
        out_latch_nxt = (idx_r == LAST_IDX);
        shreg_nxt     = shreg_r >> 1;
        idx_nxt       = idx_r + 1'b1;
        busy_nxt      = (idx_r != LAST_IDX);
      end else if (word_valid) begin
        // first bit goes straight to the output register
        out_valid_nxt = 1'b1;
        out_bit_nxt   = word_fit[0];
        out_latch_nxt = 1'b0;
        shreg_nxt     = word_fit >> 1;
        idx_nxt       = IDX_W'(1);
        busy_nxt      = 1'b1;
      end else begin
        out_valid_nxt = 1'b0;
        out_latch_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_latch_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      out_latch_r <= out_latch_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_bit_r <= out_bit_nxt;
    shreg_r   <= shreg_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_serial_bit = out_bit_r;
  assign out_latch      = out_latch_r;

`ifndef SYNTHESIS
  a_latch_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_latch_r |-> out_valid_r)
    else $error("latch mark without a valid beat");

  a_latch_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_latch_r |-> !busy_r)
    else $error("serializer still busy after the last bit");

  a_busy_idx: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r != '0))
    else $error("bit counter at zero while busy");

  a_load_first: assert property (@(posedge clk) disable iff (!rst_n)
    (word_valid && word_ready) |=> (busy_r && out_valid_r && !out_latch_r))
    else $error("word load did not start a frame");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the three-digit seven-segment shifter core. Numbers are sent
// from a queue by a clocked driver. A segment-word predictor expands each
// accepted number into its expected serial beats, and a clocked monitor
// checks every output beat against the oldest one. Both sides idle at
// random, and the receiver is held off once for a long stretch so that the
// block fills up.
// ----------------------------------------------------------------------------
module tb_top
  import tdss_pkg::*;
();

  localparam int SHIFT_LEN = 32;
  localparam int N_RANDOM  = 258;
  localparam int HOLD_CYC  = 600;

  typedef struct packed {
    logic serial_bit;
    logic latch;
  } seg_beat_t;

  // hundreds and ones positions: PCDE--------GFAB
  localparam logic [15:0] OUTER_PAT [10] = '{
    16'h7007, 16'h4001, 16'h300B, 16'h600B, 16'h400D,
    16'h600E, 16'h700E, 16'h4003, 16'h700F, 16'h600F
  };
  // tens position: ----PCDEGFAB----
  localparam logic [15:0] TENS_PAT [10] = '{
    16'h0770, 16'h0410, 16'h03B0, 16'h06B0, 16'h04D0,
    16'h06E0, 16'h07E0, 16'h0430, 16'h07F0, 16'h06F0
  };

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [NUM_W-1:0] in_number = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             out_serial_bit;
  logic             out_latch;

  logic [NUM_W-1:0] number_q [$];
  seg_beat_t        beat_exp_q [$];
  int               n_numbers = 0;
  int               n_taken = 0;
  int               n_mismatch = 0;
  int               hold_left = 0;
  logic             hold_started = 1'b0;
  logic             calm;

  three_digit_seven_segment_shifter_core #(
    .SHIFT_LENGTH(SHIFT_LEN)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_number     (in_number),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_serial_bit(out_serial_bit),
    .out_latch     (out_latch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // no idling on either side while this window of numbers goes through
  assign calm = (n_taken >= 120) && (n_taken < 170);

  function automatic logic [31:0] segment_word(input logic [NUM_W-1:0] num);
    int h, t, o;
    h = (num / 100) % 10;
    t = (num / 10) % 10;
    o = num % 10;
    return {OUTER_PAT[h], 16'h0000} | {16'h0000, TENS_PAT[t]} | {16'h0000, OUTER_PAT[o]};
  endfunction

  task automatic push_beats(input logic [NUM_W-1:0] num);
    logic [31:0] w;
    seg_beat_t   b;
    w = segment_word(num);
    for (int i = 0; i < SHIFT_LEN; i++) begin
      b.serial_bit = (i < 32) ? w[i] : 1'b0;
      b.latch      = (i == SHIFT_LEN - 1);
      beat_exp_q.push_back(b);
    end
  endtask

  task automatic note_mismatch(input string what, input int exp_v, input int act_v);
    if (n_mismatch < 10)
      $display("MISMATCH %s: expected %0d, got %0d at %0t", what, exp_v, act_v, $realtime);
    n_mismatch++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        push_beats(in_number);
        n_taken <= n_taken + 1;
      end
      if (in_valid && !in_ready) begin
        // hold the beat until taken
      end else if (number_q.size() > 0 && (calm || $urandom_range(0, 99) >= 37)) begin
        in_valid  <= 1'b1;
        in_number <= number_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, once
  always @(posedge clk) begin
    if (rst_n && !hold_started && n_taken >= 60) begin
      hold_started <= 1'b1;
      hold_left    <= HOLD_CYC;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    seg_beat_t e;
    if (rst_n && out_valid && out_ready) begin
      if (beat_exp_q.size() == 0) begin
        note_mismatch("unexpected beat, serial_bit", -1, out_serial_bit);
      end else begin
        e = beat_exp_q.pop_front();
        if (out_serial_bit !== e.serial_bit)
          note_mismatch("serial_bit", e.serial_bit, out_serial_bit);
        if (out_latch !== e.latch)
          note_mismatch("latch", e.latch, out_latch);
      end
    end
    if (!rst_n || hold_left > 0)
      out_ready <= 1'b0;
    else
      out_ready <= calm || ($urandom_range(0, 99) >= 37);
  end

  initial begin
    logic [NUM_W-1:0] dir [$];
    // every digit in every position, wrap above 999, field extremes
    dir = '{16'd0, 16'd111, 16'd222, 16'd333, 16'd444, 16'd555, 16'd666,
            16'd777, 16'd888, 16'd999, 16'd1000, 16'd65535, 16'd65534,
            16'd32768, 16'd12345, 16'd1, 16'd10, 16'd100, 16'd908,
            16'd1999, 16'd43690, 16'd21845};
    foreach (dir[i]) number_q.push_back(dir[i]);
    for (int i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(0, 1))
        number_q.push_back(NUM_W'($urandom_range(0, 65535)));
      else
        number_q.push_back(NUM_W'($urandom_range(0, 999)));
    end
    n_numbers = number_q.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (!(n_taken == n_numbers && beat_exp_q.size() == 0));
    repeat (40) @(posedge clk);
    if (n_mismatch == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== three_digit_seven_segment_shifter_core.f =====
src/tdss_pkg.sv
src/tdss_front.sv
src/tdss_queue.sv
src/tdss_back.sv
src/three_digit_seven_segment_shifter_core.sv
tb/tb_top.sv
